// ===== rtl/pidc_pkg.sv =====
package pidc_pkg;

  // configuration port geometry
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register indexes (paddr[4:2])
  localparam logic [2:0] REG_GAIN_P     = 3'd0;
  localparam logic [2:0] REG_GAIN_I     = 3'd1;
  localparam logic [2:0] REG_GAIN_D     = 3'd2;
  localparam logic [2:0] REG_OUT_LOW    = 3'd3;
  localparam logic [2:0] REG_OUT_HIGH   = 3'd4;
  localparam logic [2:0] REG_PERIOD     = 3'd5;
  localparam logic [2:0] REG_RATE       = 3'd6;

  // register reset values
  localparam logic [31:0] GAIN_P_RST   = 32'd65536;
  localparam logic [31:0] GAIN_I_RST   = 32'd0;
  localparam logic [31:0] GAIN_D_RST   = 32'd0;
  localparam logic [23:0] OUT_LOW_RST  = 24'd0;
  localparam logic [23:0] OUT_HIGH_RST = 24'd25600;
  localparam logic [15:0] PERIOD_RST   = 16'd2185;
  localparam logic [9:0]  RATE_RST     = 10'd30;

  // integral clamp, plus or minus 100.0 in Q16.8
  localparam int signed INTEG_LIMIT = 25600;

  // shared multiplier operand widths
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 26;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // op codes
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_i;
    logic signed [31:0] gain_d;
    logic signed [23:0] out_low_limit;
    logic signed [23:0] out_high_limit;
    logic [15:0]        period_frac;
    logic [9:0]         rate_hz;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INT,
    S_P,
    S_I,
    S_DR,
    S_DLO,
    S_DHI,
    S_SAT,
    S_FIN
  } state_t;

endpackage

// ===== rtl/pid_controller_step.sv =====
// Positional PID step in fixed point, with clamped integral and output.
// Input channel: in_valid / in_stall carry op, target and measured_value
// (signed Q16.8). A beat is taken when in_valid is high and in_stall low.
// op = step runs one controller update; op = clear zeroes the integral and
// the previous error and returns a drive of 0.
// Output channel: out_valid / out_stall carry drive (signed Q16.8); a beat
// completes when out_valid is high and out_stall low.
// Sequencing: a step beat passes through S_INT, S_P, S_I, S_DR, S_DLO, S_DHI,
// S_SAT and S_FIN; a clear beat goes from S_IDLE straight to S_FIN. All
// products run one after another through a single registered 32x26 signed
// multiplier, six products per step; no new beat is taken until S_FIN is left.
// in_stall is high from acceptance until the result is loaded into the
// output register; a new beat may be taken while that result still waits.
// If the receiver stalls, the finished result holds steady and the next one
// waits in the last sequencer state until the output register frees.
// Reset clears the integral, the previous error, the output valid and loads
// the register defaults (gain_p 1.0, limits 0..100.0, dt 2185/65536, 30 Hz).
// Configuration: APB registers at byte addresses 0x00..0x18; the user must write
// them only while the block is idle, which the block itself does not enforce.
module pid_controller_step (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic signed [23:0]            target,
  input  logic signed [23:0]            measured_value,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [23:0]            drive,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pidc_pkg::DATA_W-1:0]   pwdata,
  output logic [pidc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  pidc_pkg::cfg_t   cfg;
  pidc_pkg::state_t state, state_next;

  logic signed [pidc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [pidc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [pidc_pkg::MUL_P_W-1:0] prod;

  logic signed [24:0] err;
  logic signed [23:0] integral_acc;
  logic signed [24:0] last_error;
  logic signed [63:0] acc;
  logic signed [35:0] dprod;
  logic signed [50:0] dlo;
  logic               clr;

  logic               in_go;
  logic               fin_go;
  logic signed [25:0] diff;
  logic signed [41:0] int_prod_r;
  logic signed [25:0] int_delta;
  logic signed [26:0] integ_sum;
  logic signed [23:0] integ_next;
  logic signed [69:0] dfull;
  logic signed [63:0] dsat;
  logic signed [63:0] acc_r;
  logic signed [47:0] rnd;
  logic signed [47:0] hi_clamped;
  logic signed [23:0] drive_next;

  localparam logic signed [69:0] D_LIM = 70'sh1000_0000_0000_0000;

  pidc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pidc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign in_go  = in_valid & ~in_stall;
  assign fin_go = (state == pidc_pkg::S_FIN) & (~out_valid | ~out_stall);

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      pidc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = (op == pidc_pkg::OP_CLEAR) ? pidc_pkg::S_FIN : pidc_pkg::S_INT;
        end
      end
      pidc_pkg::S_INT: state_next = pidc_pkg::S_P;
      pidc_pkg::S_P:   state_next = pidc_pkg::S_I;
      pidc_pkg::S_I:   state_next = pidc_pkg::S_DR;
      pidc_pkg::S_DR:  state_next = pidc_pkg::S_DLO;
      pidc_pkg::S_DLO: state_next = pidc_pkg::S_DHI;
      pidc_pkg::S_DHI: state_next = pidc_pkg::S_SAT;
      pidc_pkg::S_SAT: state_next = pidc_pkg::S_FIN;
      pidc_pkg::S_FIN: begin
        if (fin_go) begin
          state_next = pidc_pkg::S_IDLE;
        end
      end
      default: state_next = pidc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pidc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer outputs: handshake and multiplier operand selection
  always_comb begin
    in_stall = (state != pidc_pkg::S_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      pidc_pkg::S_INT: begin
        mul_a = 32'(err);
        mul_b = 26'($signed({1'b0, cfg.period_frac}));
      end
      pidc_pkg::S_P: begin
        mul_a = $signed(cfg.gain_p);
        mul_b = 26'(err);
      end
      pidc_pkg::S_I: begin
        mul_a = $signed(cfg.gain_i);
        mul_b = 26'(integral_acc);
      end
      pidc_pkg::S_DR: begin
        mul_a = 32'(diff);
        mul_b = 26'($signed({1'b0, cfg.rate_hz}));
      end
      pidc_pkg::S_DLO: begin
        mul_a = $signed(cfg.gain_d);
        mul_b = 26'($signed({1'b0, prod[17:0]}));
      end
      pidc_pkg::S_DHI: begin
        mul_a = $signed(cfg.gain_d);
        mul_b = 26'($signed(dprod[35:18]));
      end
      default: ;
    endcase
  end

  // derivative difference
  assign diff = 26'(err) - 26'(last_error);

  // integral update: round error*dt to Q.8 and clamp
  assign int_prod_r = prod[41:0] + 42'sd32768;
  assign int_delta  = int_prod_r[41:16];
  assign integ_sum  = 27'(integral_acc) + 27'(int_delta);
  always_comb begin
    if (integ_sum > 27'(pidc_pkg::INTEG_LIMIT)) begin
      integ_next = 24'(pidc_pkg::INTEG_LIMIT);
    end else if (integ_sum < -27'(pidc_pkg::INTEG_LIMIT)) begin
      integ_next = -24'(pidc_pkg::INTEG_LIMIT);
    end else begin
      integ_next = integ_sum[23:0];
    end
  end

  // derivative term from two partial products, saturated at 2^60
  assign dfull = (70'(prod) <<< 18) + 70'(dlo);
  always_comb begin
    if (dfull > D_LIM) begin
      dsat = D_LIM[63:0];
    end else if (dfull < -D_LIM) begin
      dsat = 64'(-D_LIM);
    end else begin
      dsat = dfull[63:0];
    end
  end

  // final rounding and output clamp, high limit first then low
  assign acc_r = acc + 64'sd32768;
  assign rnd   = acc_r[63:16];
  always_comb begin
    if (rnd > 48'($signed(cfg.out_high_limit))) begin
      hi_clamped = 48'($signed(cfg.out_high_limit));
    end else begin
      hi_clamped = rnd;
    end
    if (hi_clamped < 48'($signed(cfg.out_low_limit))) begin
      drive_next = $signed(cfg.out_low_limit);
    end else begin
      drive_next = hi_clamped[23:0];
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_acc <= '0;
      last_error   <= '0;
    end else if (in_go && op == pidc_pkg::OP_CLEAR) begin
      integral_acc <= '0;
      last_error   <= '0;
    end else if (state == pidc_pkg::S_P) begin
      integral_acc <= integ_next;
    end else if (state == pidc_pkg::S_DR) begin
      last_error <= err;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_go) begin
      err <= 25'(target) - 25'(measured_value);
      clr <= op;
    end
    case (state)
      pidc_pkg::S_I:   acc   <= 64'(prod);
      pidc_pkg::S_DR:  acc   <= acc + 64'(prod);
      pidc_pkg::S_DLO: dprod <= prod[35:0];
      pidc_pkg::S_DHI: dlo   <= prod[50:0];
      pidc_pkg::S_SAT: acc   <= acc + dsat;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      drive <= (clr == pidc_pkg::OP_CLEAR) ? 24'sd0 : drive_next;
    end
  end

  // integral never leaves its clamp
  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    (integral_acc <= 24'(pidc_pkg::INTEG_LIMIT)) &&
    (integral_acc >= -24'(pidc_pkg::INTEG_LIMIT)))
    else $error("integral out of range");

  // a clear beat zeroes the controller state
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (in_go && op == pidc_pkg::OP_CLEAR) |=> (integral_acc == '0) && (last_error == '0))
    else $error("clear did not zero state");

  // a new result is only loaded from the final sequencer state
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == pidc_pkg::S_FIN)
    else $error("output valid from wrong state");

  // an accepted beat moves the sequencer out of idle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_go |=> state != pidc_pkg::S_IDLE)
    else $error("accepted beat left sequencer idle");

  // a pending result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && state == pidc_pkg::S_FIN) |=> $stable(drive))
    else $error("pending result overwritten");

endmodule

// ===== rtl/pidc_mul.sv =====
module pidc_mul (
  input  logic                                  clk,
  input  logic signed [pidc_pkg::MUL_A_W-1:0]   a,
  input  logic signed [pidc_pkg::MUL_B_W-1:0]   b,
  output logic signed [pidc_pkg::MUL_P_W-1:0]   p
);

  // one signed product a cycle, registered
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/pidc_regs.sv =====
module pidc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pidc_pkg::DATA_W-1:0]   pwdata,
  output logic [pidc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output pidc_pkg::cfg_t                cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p         <= pidc_pkg::GAIN_P_RST;
      cfg.gain_i         <= pidc_pkg::GAIN_I_RST;
      cfg.gain_d         <= pidc_pkg::GAIN_D_RST;
      cfg.out_low_limit  <= pidc_pkg::OUT_LOW_RST;
      cfg.out_high_limit <= pidc_pkg::OUT_HIGH_RST;
      cfg.period_frac    <= pidc_pkg::PERIOD_RST;
      cfg.rate_hz        <= pidc_pkg::RATE_RST;
    end else if (wr_en) begin
      case (idx)
        pidc_pkg::REG_GAIN_P:   cfg.gain_p         <= pwdata;
        pidc_pkg::REG_GAIN_I:   cfg.gain_i         <= pwdata;
        pidc_pkg::REG_GAIN_D:   cfg.gain_d         <= pwdata;
        pidc_pkg::REG_OUT_LOW:  cfg.out_low_limit  <= pwdata[23:0];
        pidc_pkg::REG_OUT_HIGH: cfg.out_high_limit <= pwdata[23:0];
        pidc_pkg::REG_PERIOD:   cfg.period_frac    <= pwdata[15:0];
        pidc_pkg::REG_RATE:     cfg.rate_hz        <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // read back, limits sign extended
  always_comb begin
    case (idx)
      pidc_pkg::REG_GAIN_P:   prdata = cfg.gain_p;
      pidc_pkg::REG_GAIN_I:   prdata = cfg.gain_i;
      pidc_pkg::REG_GAIN_D:   prdata = cfg.gain_d;
      pidc_pkg::REG_OUT_LOW:  prdata = 32'($signed(cfg.out_low_limit));
      pidc_pkg::REG_OUT_HIGH: prdata = 32'($signed(cfg.out_high_limit));
      pidc_pkg::REG_PERIOD:   prdata = {16'd0, cfg.period_frac};
      pidc_pkg::REG_RATE:     prdata = {22'd0, cfg.rate_hz};
      default:                prdata = '0;
    endcase
  end

endmodule
